// ----- sv/cmn_pkg.sv -----
// ----------------------------------------------------------------------------
// cmn_pkg: calendar month navigator shared types and constants
// Transaction types, command codes and calendar tables.
// ----------------------------------------------------------------------------
package cmn_pkg;

  localparam logic [2:0] OP_LOAD      = 3'd0;
  localparam logic [2:0] OP_NEXT_YEAR = 3'd1;
  localparam logic [2:0] OP_PREV_YEAR = 3'd2;
  localparam logic [2:0] OP_NEXT_MON  = 3'd3;
  localparam logic [2:0] OP_PREV_MON  = 3'd4;

  localparam logic [13:0] YEAR_MIN   = 14'd1;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd2000;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;

  // floor(y / 100) = (y * 5243) >> 19 for y below 16384
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  // floor(s / 7) = (s * 147) >> 10 for s below 209
  localparam int DIV7_MUL     = 147;
  localparam int DIV7_SHIFT   = 10;

  localparam int ROWS = 6;
  localparam int COLS = 7;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  load_month;
    logic [13:0] load_year;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  month_now;
    logic [13:0] year_now;
    logic [2:0]  first_weekday;
    logic [4:0]  days_in_month;
    logic [4:0]  day_mon;
    logic [4:0]  day_tue;
    logic [4:0]  day_wed;
    logic [4:0]  day_thu;
    logic [4:0]  day_fri;
    logic [4:0]  day_sat;
    logic [4:0]  day_sun;
    logic        last_row;
  } row_t;

  typedef struct packed {
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  first;
    logic [4:0]  dom;
  } month_rec_t;

  function automatic logic [2:0] month_key(input logic [3:0] m);
    logic [2:0] k;
    case (m)
      4'd1:    k = 3'd1;
      4'd2:    k = 3'd4;
      4'd3:    k = 3'd4;
      4'd4:    k = 3'd0;
      4'd5:    k = 3'd2;
      4'd6:    k = 3'd5;
      4'd7:    k = 3'd0;
      4'd8:    k = 3'd3;
      4'd9:    k = 3'd6;
      4'd10:   k = 3'd1;
      4'd11:   k = 3'd4;
      4'd12:   k = 3'd6;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:    d = 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/cmn_front.sv -----
// ----------------------------------------------------------------------------
// cmn_front: command front end
// Applies navigation commands to month/year state and works out leap year,
// month length and weekday of the 1st in a short pipeline.
// ----------------------------------------------------------------------------
module cmn_front #(
  parameter int DEPTH = 4,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmn_pkg::cmd_t     cmd,
  input  logic [LW-1:0]     level,
  output logic              push,
  output cmn_pkg::month_rec_t push_data
);
  import cmn_pkg::*;

  logic [3:0]  month, month_next;
  logic [13:0] year, year_next;
  logic        accept;
  logic        s0_valid;

  logic        p1_valid;
  logic [3:0]  p1_month;
  logic [13:0] p1_year;
  logic [6:0]  p1_q;
  logic [26:0] div100_prod;

  logic        p2_valid;
  logic [3:0]  p2_month;
  logic [13:0] p2_year;
  logic [6:0]  p2_l2;
  logic [1:0]  p2_qlo;
  logic [13:0] l2_wide;

  logic        p3_valid;
  logic [3:0]  p3_month;
  logic [13:0] p3_year;
  logic [7:0]  p3_sum;
  logic        p3_leap;
  logic        leap_c;
  logic [2:0]  cc_c;
  logic [7:0]  sum_c;

  logic        p4_valid;
  month_rec_t  p4_rec;
  logic [15:0] div7_prod;
  logic [5:0]  q7;
  logic [7:0]  res_wide;
  logic [3:0]  wd_tmp;

  logic [2:0]  inflight;

  assign inflight  = 3'(s0_valid) + 3'(p1_valid) + 3'(p2_valid) + 3'(p3_valid) + 3'(p4_valid);
  assign cmd_stall = (int'(level) + int'(inflight)) >= DEPTH;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    month_next = month;
    year_next  = year;
    case (cmd.opcode)
      OP_LOAD: begin
        if (cmd.load_month >= MONTH_JAN && cmd.load_month <= MONTH_DEC) begin
          month_next = cmd.load_month;
          if (cmd.load_year < YEAR_MIN) year_next = YEAR_MIN;
          else if (cmd.load_year > YEAR_MAX) year_next = YEAR_MAX;
          else year_next = cmd.load_year;
        end
      end
      OP_NEXT_YEAR: begin
        if (year < YEAR_MAX) year_next = year + 14'd1;
      end
      OP_PREV_YEAR: begin
        if (year > YEAR_MIN) year_next = year - 14'd1;
      end
      OP_NEXT_MON: begin
        if (month != MONTH_DEC) month_next = month + 4'd1;
        else if (year < YEAR_MAX) begin
          month_next = MONTH_JAN;
          year_next  = year + 14'd1;
        end
      end
      OP_PREV_MON: begin
        if (month != MONTH_JAN) month_next = month - 4'd1;
        else if (year > YEAR_MIN) begin
          month_next = MONTH_DEC;
          year_next  = year - 14'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      month    <= MONTH_JAN;
      year     <= YEAR_RESET;
      s0_valid <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      if (accept) begin
        month <= month_next;
        year  <= year_next;
      end
      s0_valid <= accept;
      p1_valid <= s0_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  // y / 100
  assign div100_prod = 27'(year) * 27'(DIV100_MUL);

  // y mod 100
  assign l2_wide = p1_year - 14'(p1_q) * 14'd100;

  // key-value sum; century code from (y / 100) mod 4
  always_comb begin
    leap_c = (p2_l2[1:0] == 2'd0) && (p2_l2 != 7'd0 || p2_qlo == 2'd0);
    cc_c   = 3'd6 - {p2_qlo, 1'b0};
    sum_c  = 8'(p2_l2[6:2]) + 8'd1 + 8'(month_key(p2_month)) + 8'(cc_c) + 8'(p2_l2);
    if ((p2_month == MONTH_JAN || p2_month == MONTH_FEB) && leap_c) sum_c = sum_c - 8'd1;
  end

  // sum mod 7, then shift so Monday is 0
  assign div7_prod = 16'(p3_sum) * 16'(DIV7_MUL);
  assign q7        = div7_prod[DIV7_SHIFT +: 6];
  assign res_wide  = p3_sum - 8'(q7) * 8'd7;
  assign wd_tmp    = 4'(res_wide[2:0]) + 4'd5;

  always_ff @(posedge clk) begin
    p1_month <= month;
    p1_year  <= year;
    p1_q     <= div100_prod[DIV100_SHIFT +: 7];

    p2_month <= p1_month;
    p2_year  <= p1_year;
    p2_l2    <= l2_wide[6:0];
    p2_qlo   <= p1_q[1:0];

    p3_month <= p2_month;
    p3_year  <= p2_year;
    p3_sum   <= sum_c;
    p3_leap  <= leap_c;

    p4_rec.month <= p3_month;
    p4_rec.year  <= p3_year;
    p4_rec.first <= (wd_tmp >= 4'd7) ? 3'(wd_tmp - 4'd7) : wd_tmp[2:0];
    p4_rec.dom   <= (p3_month == MONTH_FEB && p3_leap) ? 5'd29 : month_len(p3_month);
  end

  assign push      = p4_valid;
  assign push_data = p4_rec;

endmodule

// ----- sv/cmn_queue.sv -----
// ----------------------------------------------------------------------------
// cmn_queue: month record queue
// Small FIFO between the front end and the row generator.
// ----------------------------------------------------------------------------
module cmn_queue #(
  parameter int DEPTH = 4,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cmn_pkg::month_rec_t push_data,
  input  logic                pop,
  output cmn_pkg::month_rec_t pop_data,
  output logic [LW-1:0]       level
);
  import cmn_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  month_rec_t  entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) level <= level + LW'(1);
      else if (pop && !push) level <= level - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  assign pop_data = entries[rd_ptr];

endmodule

// ----- sv/cmn_back.sv -----
// ----------------------------------------------------------------------------
// cmn_back: calendar row generator
// Takes one month record and emits its six grid rows, one per cycle while row_stall is low.
// ----------------------------------------------------------------------------
module cmn_back #(
  parameter int LW = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [LW-1:0]       level,
  output logic                pop,
  input  cmn_pkg::month_rec_t pop_data,
  output logic                row_valid,
  input  logic                row_stall,
  output cmn_pkg::row_t       row
);
  import cmn_pkg::*;

  logic             busy;
  month_rec_t       rec;
  logic [2:0]       row_idx;
  logic signed [7:0] start;
  logic             adv;
  logic             last;
  logic [4:0]       cells [COLS];
  logic signed [7:0] day_s [COLS];

  assign last = (row_idx == 3'(ROWS - 1));
  assign adv  = busy && (!row_valid || !row_stall);
  assign pop  = (level != '0) && (!busy || (adv && last));

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      day_s[c] = start + 8'(c);
      if (day_s[c] >= 8'sd1 && day_s[c] <= $signed({3'b000, rec.dom}))
        cells[c] = day_s[c][4:0];
      else
        cells[c] = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      row_valid <= 1'b0;
    end else begin
      if (adv) row_valid <= 1'b1;
      else if (!row_stall) row_valid <= 1'b0;
      if (pop) busy <= 1'b1;
      else if (adv && last) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec     <= pop_data;
      row_idx <= '0;
      start   <= 8'sd1 - $signed({5'b00000, pop_data.first});
    end else if (adv) begin
      row_idx <= row_idx + 3'd1;
      start   <= start + 8'sd7;
    end
    if (adv) begin
      row.month_now     <= rec.month;
      row.year_now      <= rec.year;
      row.first_weekday <= rec.first;
      row.days_in_month <= rec.dom;
      row.day_mon       <= cells[0];
      row.day_tue       <= cells[1];
      row.day_wed       <= cells[2];
      row.day_thu       <= cells[3];
      row.day_fri       <= cells[4];
      row.day_sat       <= cells[5];
      row.day_sun       <= cells[6];
      row.last_row      <= last;
    end
  end

endmodule

// ----- sv/calendar_month_navigator_top.sv -----
// ----------------------------------------------------------------------------
// calendar_month_navigator_top: calendar month navigator
// Navigates a month/year and emits its calendar grid as six rows.
//
//   channel | dir | handshake            | payload
//   cmd     | in  | cmd_valid/cmd_stall  | cmn_pkg::cmd_t
//   row     | out | row_valid/row_stall  | cmn_pkg::row_t, six per command
//
// Each command yields six grid rows; the row generator takes the next record with its last row.
// A month record passes front-end stages s0 and p1 to p4 and the queue before its rows appear.
// Up to QUEUE_DEPTH month records wait between front end and row generator.
// Reset restores January 2000 and empties the pipeline and queue.
// ----------------------------------------------------------------------------
module calendar_month_navigator_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  cmn_pkg::cmd_t  cmd,
  output logic           row_valid,
  input  logic           row_stall,
  output cmn_pkg::row_t  row
);
  import cmn_pkg::*;

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  logic          push;
  month_rec_t    push_data;
  logic          pop;
  month_rec_t    pop_data;
  logic [LW-1:0] level;

  cmn_front #(.DEPTH(QUEUE_DEPTH), .LW(LW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .level     (level),
    .push      (push),
    .push_data (push_data)
  );

  cmn_queue #(.DEPTH(QUEUE_DEPTH), .LW(LW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .level     (level)
  );

  cmn_back #(.LW(LW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .level     (level),
    .pop       (pop),
    .pop_data  (pop_data),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row       (row)
  );

endmodule

// ----- sv/cmn_checker.sv -----
// ----------------------------------------------------------------------------
// cmn_checker: port checks for the calendar month navigator
// Watches the top-level ports and flags grid sequencing errors.
// ----------------------------------------------------------------------------
module cmn_checker (
  input logic          clk,
  input logic          rst,
  input logic          row_valid,
  input logic          row_stall,
  input cmn_pkg::row_t row
);
  import cmn_pkg::*;

  logic [2:0] row_cnt;
  logic       row_take;

  assign row_take = row_valid && !row_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (row_take) begin
      row_cnt <= row.last_row ? 3'd0 : row_cnt + 3'd1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !row_valid)
    else $error("row_valid high after reset");

  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_stall |=> row_valid && $stable(row))
    else $error("stalled row transaction changed");

  a_six_rows: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> row.last_row == (row_cnt == 3'(ROWS - 1)))
    else $error("last_row out of step with six-row grid");

  a_first_row: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_cnt == 3'd0 |->
      row.day_sun != 5'd0 && ((row.first_weekday == 3'd0) == (row.day_mon == 5'd1)))
    else $error("first grid row does not match first weekday");

endmodule

bind calendar_month_navigator_top cmn_checker u_checker (.*);
